[design/pol_pkg.sv]
package pol_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_AT    = 3'd0,
        CMD_DELETE_AT    = 3'd1,
        CMD_ADD_FRONT    = 3'd2,
        CMD_ADD_REAR     = 3'd3,
        CMD_DELETE_FRONT = 3'd4,
        CMD_DELETE_REAR  = 3'd5,
        CMD_SEARCH       = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [CNT_W-1:0]        position;
        logic signed [31:0]      data_in;
    } t_in;

    typedef struct packed {
        logic                    ok;
        logic signed [31:0]      data_out;
        logic [CNT_W-1:0]        length;
        logic                    full_res;
    } t_out;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [CNT_W-1:0]        pos;
        logic [CNT_W-1:0]        count;
    } t_cell_ctl;

endpackage

[design/pol_cell.sv]
module pol_cell (
    input  logic                            i_clk,
    input  pol_pkg::t_cell_ctl              i_ctl,
    input  logic [pol_pkg::CNT_W-1:0]       i_idx,
    input  logic [pol_pkg::VALUE_WIDTH-1:0] i_data,
    input  logic [pol_pkg::VALUE_WIDTH-1:0] i_left,
    input  logic [pol_pkg::VALUE_WIDTH-1:0] i_right,
    output logic [pol_pkg::VALUE_WIDTH-1:0] o_val,
    output logic                            o_match,
    output logic [pol_pkg::VALUE_WIDTH-1:0] o_sel
);

    logic [pol_pkg::VALUE_WIDTH-1:0] r_val;
    logic [pol_pkg::VALUE_WIDTH-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && i_idx == i_ctl.pos) begin
            n_val = i_data;
        end else if (i_ctl.ins && i_idx > i_ctl.pos) begin
            n_val = i_left;
        end else if (i_ctl.del && i_idx >= i_ctl.pos) begin
            n_val = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    // only live entries may report a hit
    assign o_match = (i_idx < i_ctl.count) && (r_val == i_data);
    assign o_sel   = (i_idx == i_ctl.pos) ? r_val : '0;

endmodule

[design/positional_ordered_list.sv]
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in  (pol_pkg::t_in)
// out     | output    | o_out_valid / i_out_ready  | o_out (pol_pkg::t_out)
//
// on every command all cells shift, load or compare in parallel
// and the result lands in the output register at the accepting edge
// a new beat is taken whenever the output register is empty or being drained
// synchronous active-low reset empties the list; entry values are not cleared
module positional_ordered_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pol_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pol_pkg::t_out o_out
);

    localparam int VW = pol_pkg::VALUE_WIDTH;
    localparam int CW = pol_pkg::CNT_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    pol_pkg::t_out       r_out;
    pol_pkg::t_out       n_out;
    pol_pkg::t_cell_ctl  cell_ctl;
    logic                accept;
    logic                is_full;
    logic                is_ins;
    logic                is_del;
    logic                ins_ok;
    logic                del_ok;
    logic [CW-1:0]       pos;
    logic [VW-1:0]       data_val;
    logic                found;
    logic [VW-1:0]       removed;

    logic [VW-1:0]       cell_val   [pol_pkg::CAPACITY];
    logic [VW-1:0]       cell_left  [pol_pkg::CAPACITY];
    logic [VW-1:0]       cell_right [pol_pkg::CAPACITY];
    logic [VW-1:0]       cell_sel   [pol_pkg::CAPACITY];
    logic [pol_pkg::CAPACITY-1:0] cell_match;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign data_val   = VW'(i_in.data_in);
    assign is_full    = (r_count == CW'(pol_pkg::CAPACITY));

    always_comb begin
        is_ins = 1'b0;
        is_del = 1'b0;
        pos    = i_in.position;
        case (i_in.cmd)
            pol_pkg::CMD_INSERT_AT: begin
                is_ins = 1'b1;
            end
            pol_pkg::CMD_ADD_FRONT: begin
                is_ins = 1'b1;
                pos    = '0;
            end
            pol_pkg::CMD_ADD_REAR: begin
                is_ins = 1'b1;
                pos    = r_count;
            end
            pol_pkg::CMD_DELETE_AT: begin
                is_del = 1'b1;
            end
            pol_pkg::CMD_DELETE_FRONT: begin
                is_del = 1'b1;
                pos    = '0;
            end
            pol_pkg::CMD_DELETE_REAR: begin
                is_del = 1'b1;
                pos    = r_count - CW'(1);
            end
            default: begin
            end
        endcase
    end

    // full check comes ahead of the position check
    assign ins_ok = is_ins && !is_full && (pos <= r_count);
    assign del_ok = is_del && (r_count != '0) && (pos < r_count);

    assign cell_ctl.ins   = accept && ins_ok;
    assign cell_ctl.del   = accept && del_ok;
    assign cell_ctl.pos   = pos;
    assign cell_ctl.count = r_count;

    genvar g;
    generate
        for (g = 0; g < pol_pkg::CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign cell_left[g] = '0;
            end else begin : g_mid_l
                assign cell_left[g] = cell_val[g-1];
            end
            if (g == pol_pkg::CAPACITY - 1) begin : g_last
                assign cell_right[g] = '0;
            end else begin : g_mid_r
                assign cell_right[g] = cell_val[g+1];
            end
            pol_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_idx   (CW'(g)),
                .i_data  (data_val),
                .i_left  (cell_left[g]),
                .i_right (cell_right[g]),
                .o_val   (cell_val[g]),
                .o_match (cell_match[g]),
                .o_sel   (cell_sel[g])
            );
        end
    endgenerate

    always_comb begin
        removed = '0;
        for (int k = 0; k < pol_pkg::CAPACITY; k++) begin
            removed = removed | cell_sel[k];
        end
    end

    assign found = |cell_match;

    always_comb begin
        n_count = r_count;
        if (accept && ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (accept && del_ok) begin
            n_count = r_count - CW'(1);
        end
        n_out          = r_out;
        n_out.ok       = ins_ok || del_ok || (i_in.cmd == pol_pkg::CMD_SEARCH && found);
        n_out.data_out = del_ok ? 32'(signed'(removed)) : '0;
        n_out.length   = n_count;
        n_out.full_res = is_ins && is_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[tb/pol_list_checker.sv]
module pol_list_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  pol_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  pol_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_results,
    output int            o_ok_count,
    output int            o_full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] shadow_list[$];
    pol_pkg::t_out      pending_results[$];
    int                 fail_total;
    int                 result_total;
    int                 ok_total;
    int                 full_total;

    initial begin
        fail_total   = 0;
        result_total = 0;
        ok_total     = 0;
        full_total   = 0;
    end

    // applies one command to the shadow list and returns the result it should give
    function automatic pol_pkg::t_out apply_list_op(pol_pkg::t_in beat);
        pol_pkg::t_out res;
        int   fill;
        int   at;
        res  = '0;
        fill = shadow_list.size();
        case (pol_pkg::t_cmd'(beat.cmd))
            pol_pkg::CMD_INSERT_AT, pol_pkg::CMD_ADD_FRONT, pol_pkg::CMD_ADD_REAR: begin
                if (fill >= pol_pkg::CAPACITY) begin
                    res.full_res = 1'b1;
                end else begin
                    if (beat.cmd == pol_pkg::CMD_INSERT_AT)
                        at = int'(beat.position);
                    else if (beat.cmd == pol_pkg::CMD_ADD_FRONT)
                        at = 0;
                    else
                        at = fill;
                    if (at <= fill) begin
                        if (at == fill)
                            shadow_list.push_back(beat.data_in);
                        else
                            shadow_list.insert(at, beat.data_in);
                        res.ok = 1'b1;
                    end
                end
            end
            pol_pkg::CMD_DELETE_AT, pol_pkg::CMD_DELETE_FRONT,
            pol_pkg::CMD_DELETE_REAR: begin
                if (fill > 0) begin
                    if (beat.cmd == pol_pkg::CMD_DELETE_AT)
                        at = int'(beat.position);
                    else if (beat.cmd == pol_pkg::CMD_DELETE_FRONT)
                        at = 0;
                    else
                        at = fill - 1;
                    if (at < fill) begin
                        res.data_out = shadow_list[at];
                        shadow_list.delete(at);
                        res.ok = 1'b1;
                    end
                end
            end
            pol_pkg::CMD_SEARCH: begin
                foreach (shadow_list[k])
                    if (shadow_list[k] == beat.data_in)
                        res.ok = 1'b1;
            end
            default: ;
        endcase
        res.length = pol_pkg::CNT_W'(shadow_list.size());
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        pol_pkg::t_out got;
        pol_pkg::t_out want;
        if (!i_rst_n) begin
            shadow_list.delete();
            pending_results.delete();
        end else begin
            // drain first: a result never belongs to the beat taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = i_out;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: %p", got);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("ok", 32'(want.ok), 32'(got.ok));
                    check_field("data_out", want.data_out, got.data_out);
                    check_field("length", 32'(want.length), 32'(got.length));
                    check_field("full_res", 32'(want.full_res), 32'(got.full_res));
                    result_total++;
                    if (want.ok)
                        ok_total++;
                    if (want.full_res)
                        full_total++;
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_list_op(i_in));
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
        o_results    <= result_total;
        o_ok_count   <= ok_total;
        o_full_count <= full_total;
    end

endmodule

[tb/positional_ordered_list_tb.sv]
module positional_ordered_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pol_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_BEATS = 1250;
    localparam int PHASE_LEN    = 40;

    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    pol_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_ready = 1'b1;
    pol_pkg::t_out o_out;

    int   fail_count;
    int   pending;
    int   results;
    int   ok_count;
    int   full_count;

    // when set, neither side inserts idle cycles
    bit   calm = 1'b0;
    int   out_hold = 0;
    int   out_gap;

    logic [31:0] value_pool[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                   32'h0000_0000, 32'h5555_5555, 32'haaaa_aaaa};

    always #6 i_clk = ~i_clk;

    positional_ordered_list uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    pol_list_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results),
        .o_ok_count  (ok_count),
        .o_full_count(full_count)
    );

    // result side back-pressure: a fresh random-length stall after each beat
    always @(posedge i_clk) begin
        if (i_out_ready && o_out_valid) begin
            out_gap = calm ? 0 : $urandom_range(0, 4);
            if (out_gap != 0) begin
                i_out_ready <= 1'b0;
                out_hold    <= out_gap;
            end
        end else if (!i_out_ready) begin
            if (out_hold <= 1)
                i_out_ready <= 1'b1;
            else
                out_hold <= out_hold - 1;
        end
    end

    task automatic send_beat(input logic [pol_pkg::CMD_W-1:0] cmd, input int pos,
                             input logic [31:0] data);
        int           gap;
        pol_pkg::t_in beat;
        beat.cmd      = cmd;
        beat.position = pol_pkg::CNT_W'(pos);
        beat.data_in  = data;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    function automatic logic [pol_pkg::CMD_W-1:0] pick_cmd(input int phase);
        int r;
        int ins_pct;
        r = $urandom_range(0, 99);
        case (phase)
            PH_GROW:   ins_pct = 70;
            PH_SHRINK: ins_pct = 25;
            default:   ins_pct = 45;
        endcase
        if (r == 99)
            return CMD_UNUSED;
        if (r < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       return pol_pkg::CMD_INSERT_AT;
                1:       return pol_pkg::CMD_ADD_FRONT;
                default: return pol_pkg::CMD_ADD_REAR;
            endcase
        end
        if (r < ins_pct + 12)
            return pol_pkg::CMD_SEARCH;
        case ($urandom_range(0, 2))
            0:       return pol_pkg::CMD_DELETE_AT;
            1:       return pol_pkg::CMD_DELETE_FRONT;
            default: return pol_pkg::CMD_DELETE_REAR;
        endcase
    endfunction

    initial begin
        int phase;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every delete, the search, the unused command and an insert past the end are refused
        send_beat(pol_pkg::CMD_DELETE_FRONT, 0, 32'h0);
        send_beat(pol_pkg::CMD_DELETE_REAR, 0, 32'h0);
        send_beat(pol_pkg::CMD_DELETE_AT, 0, 32'h0);
        send_beat(pol_pkg::CMD_SEARCH, 0, 32'h0);
        send_beat(CMD_UNUSED, 31, 32'hffff_ffff);
        send_beat(pol_pkg::CMD_INSERT_AT, 1, 32'h1234_5678);

        // fill to capacity with every insert flavor and the extreme values
        for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
            case (i % 3)
                0:       send_beat(pol_pkg::CMD_ADD_REAR, 0,
                                   i < 6 ? value_pool[i] : $urandom);
                1:       send_beat(pol_pkg::CMD_ADD_FRONT, 0,
                                   i < 6 ? value_pool[i] : $urandom);
                default: send_beat(pol_pkg::CMD_INSERT_AT, i / 2,
                                   i < 6 ? value_pool[i] : $urandom);
            endcase
        end

        // full list refuses inserts before looking at the position, then deletes and searches run on it
        send_beat(pol_pkg::CMD_INSERT_AT, 16, 32'h0);
        send_beat(pol_pkg::CMD_ADD_REAR, 0, 32'h1);
        send_beat(pol_pkg::CMD_DELETE_AT, 16, 32'h0);
        send_beat(pol_pkg::CMD_DELETE_AT, 7, 32'h0);
        send_beat(pol_pkg::CMD_DELETE_FRONT, 0, 32'h0);
        send_beat(pol_pkg::CMD_DELETE_REAR, 0, 32'h0);
        send_beat(pol_pkg::CMD_SEARCH, 0, 32'h5555_5555);
        send_beat(pol_pkg::CMD_SEARCH, 0, 32'h0bad_cafe);

        phase = PH_MIXED;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % PHASE_LEN == 0) begin
                phase = $urandom_range(0, 2);
                calm  = ($urandom_range(0, 3) == 0);
            end
            // positions lean low so short lists see valid ones too
            send_beat(pick_cmd(phase), $urandom_range(0, $urandom_range(0, 16)),
                      pick_value());
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("checked %0d result beats: %0d succeeded or hit, %0d refused as full",
                 results, ok_count, full_count);
        if (fail_count == 0)
            $display("positional_ordered_list_tb: PASS");
        else
            $display("positional_ordered_list_tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("positional_ordered_list_tb: FAIL");
        $finish;
    end

endmodule
